@@ hdl/bls_pkg.sv @@
// ----------------------------------------------------------------------------
// bls_pkg: shared types and constants for bone length statistics
// Holds the controller state type, the command/status structs and the
// fixed bone parent table.
// ----------------------------------------------------------------------------
package bls_pkg;

  localparam int unsigned COORD_W  = 16;
  localparam int unsigned LEN_W    = 17;
  localparam int unsigned SUM_W    = 40;
  localparam int unsigned SQ_W     = 56;
  localparam int unsigned D2_W     = 36;
  localparam int unsigned IDX_W    = 5;
  localparam int unsigned OCNT_W   = 20;
  localparam int unsigned SQRT_STEPS = D2_W / 2;
  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
  localparam logic [SQ_W-1:0]  SQ_MAX  = {SQ_W{1'b1}};

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_DIFF,
    ST_SQR,
    ST_SQRT,
    ST_STAT_RD,
    ST_STAT,
    ST_DIV,
    ST_WRITE,
    ST_OUT
  } bls_state_t;

  typedef struct packed {
    logic load;
    logic count_up;
    logic read_parent;
    logic diff;
    logic square;
    logic sqrt_init;
    logic sqrt_step;
    logic stat_read;
    logic stat;
    logic div_init;
    logic div_step;
    logic write_back;
    logic out_valid;
  } bls_cmd_t;

  typedef struct packed {
    logic is_root;
    logic sqrt_done;
    logic div_done;
  } bls_sts_t;

  // Parent joint of each joint; joints beyond the table use j-1.
  function automatic logic [IDX_W-1:0] parent_of(input logic [IDX_W-1:0] j);
    logic [IDX_W-1:0] p;
    unique case (j)
      5'd1:  p = 5'd0;
      5'd2:  p = 5'd1;
      5'd3:  p = 5'd2;
      5'd4:  p = 5'd2;
      5'd5:  p = 5'd4;
      5'd6:  p = 5'd5;
      5'd7:  p = 5'd6;
      5'd8:  p = 5'd2;
      5'd9:  p = 5'd8;
      5'd10: p = 5'd9;
      5'd11: p = 5'd10;
      5'd12: p = 5'd0;
      5'd13: p = 5'd12;
      5'd14: p = 5'd13;
      5'd15: p = 5'd14;
      5'd16: p = 5'd0;
      5'd17: p = 5'd16;
      5'd18: p = 5'd17;
      5'd19: p = 5'd18;
      default: p = j - 5'd1;
    endcase
    return p;
  endfunction

endpackage

@@ hdl/bls_ctrl.sv @@
// ----------------------------------------------------------------------------
// bls_ctrl: sequencer for bone length statistics
// Steps one request through read and, unless it is joint 0, difference,
// square, root, statistics, mean divide and write-back, then presents the result.
// ----------------------------------------------------------------------------
module bls_ctrl import bls_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_fire,
  input  logic     out_ready,
  input  bls_sts_t sts,
  output logic     in_ready,
  output bls_cmd_t cmd
);

  bls_state_t state_r, state_nxt;

  // Advance state
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:    if (in_fire) state_nxt = ST_READ;
      ST_READ:    state_nxt = sts.is_root ? ST_IDLE : ST_DIFF;
      ST_DIFF:    state_nxt = ST_SQR;
      ST_SQR:     state_nxt = ST_SQRT;
      ST_SQRT:    if (sts.sqrt_done) state_nxt = ST_STAT_RD;
      ST_STAT_RD: state_nxt = ST_STAT;
      ST_STAT:    state_nxt = ST_DIV;
      ST_DIV:     if (sts.div_done) state_nxt = ST_WRITE;
      ST_WRITE:   state_nxt = ST_OUT;
      ST_OUT:     if (out_ready) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd         = '0;
    in_ready    = (state_r == ST_IDLE);
    cmd.load    = in_fire;
    unique case (state_r)
      ST_IDLE:    ;
      ST_READ: begin
        cmd.read_parent = 1'b1;
        cmd.count_up    = sts.is_root;
      end
      ST_DIFF:    cmd.diff = 1'b1;
      ST_SQR: begin
        cmd.square    = 1'b1;
        cmd.sqrt_init = 1'b1;
      end
      ST_SQRT:    cmd.sqrt_step = 1'b1;
      ST_STAT_RD: cmd.stat_read = 1'b1;
      ST_STAT: begin
        cmd.stat     = 1'b1;
        cmd.div_init = 1'b1;
      end
      ST_DIV:     cmd.div_step = 1'b1;
      ST_WRITE:   cmd.write_back = 1'b1;
      ST_OUT:     cmd.out_valid = 1'b1;
      default:    ;
    endcase
  end

endmodule

@@ hdl/bls_datapath.sv @@
// ----------------------------------------------------------------------------
// bls_datapath: storage and arithmetic for bone length statistics
// Joint memory, per-bone statistics memory, squarer, bit-serial square
// root and restoring divider for the mean.
// ----------------------------------------------------------------------------
module bls_datapath import bls_pkg::*; #(
  parameter int unsigned NUM_JOINTS = 20,
  parameter int unsigned COUNT_BITS = 20
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bls_cmd_t             cmd,
  input  logic [IDX_W-1:0]     in_joint_index,
  input  logic signed [COORD_W-1:0] in_pos_x,
  input  logic signed [COORD_W-1:0] in_pos_y,
  input  logic signed [COORD_W-1:0] in_pos_z,
  output bls_sts_t             sts,
  output logic [IDX_W-1:0]     out_bone_index,
  output logic [LEN_W-1:0]     out_bone_length,
  output logic [SUM_W-1:0]     out_length_sum,
  output logic [LEN_W-1:0]     out_length_min,
  output logic [LEN_W-1:0]     out_length_max,
  output logic [LEN_W-1:0]     out_length_mean,
  output logic [SQ_W-1:0]      out_length_sq_sum,
  output logic [OCNT_W-1:0]    out_sample_count
);

  localparam int unsigned NUM_BONES = NUM_JOINTS - 1;
  localparam int unsigned JA_W = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
  localparam int unsigned BA_W = (NUM_BONES > 1) ? $clog2(NUM_BONES) : 1;
  localparam int unsigned ST_W = SUM_W + 3 * LEN_W + SQ_W;
  localparam int unsigned STEP_W = $clog2(SQRT_STEPS + 1);
  localparam int unsigned DSTEP_W = $clog2(SUM_W + 1);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  // Item registers
  logic [IDX_W-1:0]            idx_r;
  logic signed [COORD_W-1:0]   px_r, py_r, pz_r;
  logic [3*COORD_W-1:0]        joint_mem [NUM_JOINTS];
  logic [3*COORD_W-1:0]        par_r;
  logic [COUNT_BITS-1:0]       cnt_r;
  logic signed [COORD_W:0]     dx_r, dy_r, dz_r;
  logic [D2_W-1:0]             d2_r;
  logic [D2_W-1:0]             rem_r;
  logic [LEN_W+1:0]            root_r;
  logic [STEP_W-1:0]           sstep_r;
  logic [LEN_W-1:0]            len_r;
  logic [ST_W-1:0]             stat_mem [NUM_BONES];
  logic [NUM_BONES-1:0]        stat_vld_r;
  logic [ST_W-1:0]             stat_rd_r;
  logic                        stat_vld_rd_r;
  logic [SUM_W-1:0]            sum_r;
  logic [LEN_W-1:0]            min_r, max_r, mean_r;
  logic [SQ_W-1:0]             sq_r;
  logic [SUM_W-1:0]            dq_r;
  logic [COUNT_BITS:0]         drem_r;
  logic [DSTEP_W-1:0]          dstep_r;
  logic [JA_W-1:0]             jaddr;
  logic [BA_W-1:0]             baddr;
  logic [IDX_W-1:0]            par_idx;

  assign jaddr   = idx_r[JA_W-1:0];
  assign par_idx = parent_of(idx_r);
  assign baddr   = BA_W'(idx_r - IDX_W'(1));

  // Capture request and store the joint
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      idx_r <= in_joint_index;
      px_r  <= in_pos_x;
      py_r  <= in_pos_y;
      pz_r  <= in_pos_z;
    end
    if (cmd.read_parent) begin
      joint_mem[jaddr] <= {px_r, py_r, pz_r};
      par_r <= joint_mem[par_idx[JA_W-1:0]];
    end
  end

  assign sts.is_root = (idx_r == '0);

  // Skeleton counter, saturating
  always_ff @(posedge clk) begin
    if (!rst_n)                             cnt_r <= '0;
    else if (cmd.count_up && cnt_r != CNT_MAX) cnt_r <= cnt_r + COUNT_BITS'(1);
  end

  // Squares of the differences, full width
  logic signed [2*COORD_W+1:0] sqx, sqy, sqz;
  assign sqx = dx_r * dx_r;
  assign sqy = dy_r * dy_r;
  assign sqz = dz_r * dz_r;

  // Differences, then sum of squares
  always_ff @(posedge clk) begin
    if (cmd.diff) begin
      dx_r <= (COORD_W+1)'(px_r) - (COORD_W+1)'($signed(par_r[3*COORD_W-1:2*COORD_W]));
      dy_r <= (COORD_W+1)'(py_r) - (COORD_W+1)'($signed(par_r[2*COORD_W-1:COORD_W]));
      dz_r <= (COORD_W+1)'(pz_r) - (COORD_W+1)'($signed(par_r[COORD_W-1:0]));
    end
    if (cmd.square) begin
      d2_r <= {2'b00, sqx} + {2'b00, sqy} + {2'b00, sqz};
    end
  end

  // Bit-serial square root, one result bit a cycle
  logic [D2_W-1:0] d2_sh;
  logic [D2_W+1:0] trial;
  logic [D2_W-1:0] rem_sh;
  always_comb begin
    d2_sh  = d2_r << {sstep_r, 1'b0};
    rem_sh = {rem_r[D2_W-3:0], d2_sh[D2_W-1:D2_W-2]};
    trial  = {(D2_W+2-LEN_W-4)'(0), root_r, 2'b01};
  end
  logic [D2_W+1:0] rem_ext;
  assign rem_ext = {2'b00, rem_sh};

  always_ff @(posedge clk) begin
    if (cmd.sqrt_init) begin
      rem_r   <= '0;
      root_r  <= '0;
      sstep_r <= '0;
    end else if (cmd.sqrt_step && sstep_r != STEP_W'(SQRT_STEPS)) begin
      sstep_r <= sstep_r + STEP_W'(1);
      if (rem_ext >= trial) begin
        rem_r  <= D2_W'(rem_ext - trial);
        root_r <= {root_r[LEN_W:0], 1'b1};
      end else begin
        rem_r  <= rem_sh;
        root_r <= {root_r[LEN_W:0], 1'b0};
      end
    end
  end
  assign sts.sqrt_done = (sstep_r == STEP_W'(SQRT_STEPS));

  // Saturate root to length
  always_ff @(posedge clk) begin
    if (cmd.stat_read) len_r <= (root_r > (LEN_W+2)'(LEN_MAX)) ? LEN_MAX : root_r[LEN_W-1:0];
  end

  // Statistics memory read and write-back
  always_ff @(posedge clk) begin
    if (cmd.stat_read) stat_rd_r <= stat_mem[baddr];
    if (cmd.write_back) stat_mem[baddr] <= {sum_r, min_r, max_r, mean_r, sq_r};
  end
  always_ff @(posedge clk) begin
    if (!rst_n)               stat_vld_r <= '0;
    else if (cmd.write_back)  stat_vld_r[baddr] <= 1'b1;
  end
  always_ff @(posedge clk) begin
    if (cmd.stat_read) stat_vld_rd_r <= stat_vld_r[baddr];
  end

  // Update statistics
  logic [SUM_W-1:0]   o_sum;
  logic [LEN_W-1:0]   o_min, o_max;
  logic [SQ_W-1:0]    o_sq;
  logic [SUM_W:0]     sum_add;
  logic [SQ_W:0]      sq_add;
  logic [2*LEN_W-1:0] len_sq;
  assign len_sq = len_r * len_r;
  always_comb begin
    o_sum = stat_vld_rd_r ? stat_rd_r[ST_W-1 -: SUM_W] : '0;
    o_min = stat_vld_rd_r ? stat_rd_r[SQ_W+3*LEN_W-1 -: LEN_W] : LEN_MAX;
    o_max = stat_vld_rd_r ? stat_rd_r[SQ_W+2*LEN_W-1 -: LEN_W] : '0;
    o_sq  = stat_vld_rd_r ? stat_rd_r[SQ_W-1:0] : '0;
    sum_add = {1'b0, o_sum} + (SUM_W+1)'(len_r);
    sq_add  = {1'b0, o_sq} + (SQ_W+1)'(len_sq);
  end
  always_ff @(posedge clk) begin
    if (cmd.stat) begin
      sum_r <= sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
      min_r <= (len_r < o_min) ? len_r : o_min;
      max_r <= (len_r > o_max) ? len_r : o_max;
      sq_r  <= sq_add[SQ_W] ? SQ_MAX : sq_add[SQ_W-1:0];
    end
  end

  // Restoring divider: mean = sum / count
  logic [COUNT_BITS:0] dsh;
  assign dsh = {drem_r[COUNT_BITS-1:0], dq_r[SUM_W-1]};
  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      dq_r    <= sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
      drem_r  <= '0;
      dstep_r <= '0;
    end else if (cmd.div_step && dstep_r != DSTEP_W'(SUM_W)) begin
      dstep_r <= dstep_r + DSTEP_W'(1);
      if (dsh >= {1'b0, cnt_r}) begin
        drem_r <= dsh - {1'b0, cnt_r};
        dq_r   <= {dq_r[SUM_W-2:0], 1'b1};
      end else begin
        drem_r <= dsh;
        dq_r   <= {dq_r[SUM_W-2:0], 1'b0};
      end
    end
  end
  assign sts.div_done = (dstep_r == DSTEP_W'(SUM_W));

  always_ff @(posedge clk) begin
    if (cmd.write_back) begin
      if (cnt_r == '0)                      mean_r <= '0;
      else if (dq_r > SUM_W'(LEN_MAX))      mean_r <= LEN_MAX;
      else                                  mean_r <= dq_r[LEN_W-1:0];
    end
  end

  assign out_bone_index    = idx_r - IDX_W'(1);
  assign out_bone_length   = len_r;
  assign out_length_sum    = sum_r;
  assign out_length_min    = min_r;
  assign out_length_max    = max_r;
  assign out_length_mean   = mean_r;
  assign out_length_sq_sum = sq_r;
  assign out_sample_count  = OCNT_W'(cnt_r);

endmodule

@@ hdl/bone_length_statistics.sv @@
// ----------------------------------------------------------------------------
// bone_length_statistics: per-bone length statistics from skeleton joints
// Measures each tracked bone and keeps its sum, min, max, mean and
// sum of squares.
// ----------------------------------------------------------------------------
//  channel | dir | handshake            | payload
//  in_     | in  | in_valid/in_ready    | joint_index, is_tracked, pos_x/y/z
//  out_    | out | out_valid/out_ready  | bone_index .. sample_count
//
//  One request at a time. A joint 0 request returns to idle after the
//  read; an ignored request leaves the block idle. A bone steps through
//  read, difference, square, root, statistics and divide, then waits in
//  the result state for as long as out_ready stays low.
//  Reset clears the skeleton count and per-bone valid bits at once.
//  A stalled result holds and blocks the next request.
// ----------------------------------------------------------------------------
module bone_length_statistics import bls_pkg::*; #(
  parameter int unsigned NUM_JOINTS = 20,
  parameter int unsigned COUNT_BITS = 20
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [IDX_W-1:0]          in_joint_index,
  input  logic                      in_is_tracked,
  input  logic signed [COORD_W-1:0] in_pos_x,
  input  logic signed [COORD_W-1:0] in_pos_y,
  input  logic signed [COORD_W-1:0] in_pos_z,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [IDX_W-1:0]          out_bone_index,
  output logic [LEN_W-1:0]          out_bone_length,
  output logic [SUM_W-1:0]          out_length_sum,
  output logic [LEN_W-1:0]          out_length_min,
  output logic [LEN_W-1:0]          out_length_max,
  output logic [LEN_W-1:0]          out_length_mean,
  output logic [SQ_W-1:0]           out_length_sq_sum,
  output logic [OCNT_W-1:0]         out_sample_count
);

  bls_cmd_t cmd;
  bls_sts_t sts;
  logic     rdy;
  logic     in_fire;

  // Drop untracked or out-of-range joints at the port
  assign in_ready = rdy;
  assign in_fire  = in_valid && rdy && in_is_tracked &&
                    (32'(in_joint_index) < NUM_JOINTS);

  bls_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .out_ready (out_ready),
    .sts       (sts),
    .in_ready  (rdy),
    .cmd       (cmd)
  );

  bls_datapath #(
    .NUM_JOINTS (NUM_JOINTS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_joint_index    (in_joint_index),
    .in_pos_x          (in_pos_x),
    .in_pos_y          (in_pos_y),
    .in_pos_z          (in_pos_z),
    .sts               (sts),
    .out_bone_index    (out_bone_index),
    .out_bone_length   (out_bone_length),
    .out_length_sum    (out_length_sum),
    .out_length_min    (out_length_min),
    .out_length_max    (out_length_max),
    .out_length_mean   (out_length_mean),
    .out_length_sq_sum (out_length_sq_sum),
    .out_sample_count  (out_sample_count)
  );

  assign out_valid = cmd.out_valid;

`ifndef SYNTHESIS
  // No new request while a result waits
  a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("in_ready during result");
  // Result stays until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  // Min never exceeds max on a reported result
  a_min_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_length_min <= out_length_max) else $error("min above max");
`endif

endmodule

@@ dv/bone_length_statistics_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bone_length_statistics_tb: self-checking bench for bone length statistics
// Sends skeleton joints over the request channel, predicts each bone result
// with a local model of the length/statistics math and compares every field.
// ----------------------------------------------------------------------------
module bone_length_statistics_tb;
  import bls_pkg::*;

  localparam int unsigned NJ = 20;
  localparam int unsigned NB = NJ - 1;
  localparam longint unsigned CNT_MAX = (64'd1 << 20) - 1;
  localparam longint unsigned CYCLE_LIMIT = 1500000;
  localparam int unsigned HOLD_CYCLES = 400;

  typedef struct packed {
    logic [IDX_W-1:0]  bone;
    logic [LEN_W-1:0]  len;
    logic [SUM_W-1:0]  sum;
    logic [LEN_W-1:0]  lmin;
    logic [LEN_W-1:0]  lmax;
    logic [LEN_W-1:0]  mean;
    logic [SQ_W-1:0]   sq;
    logic [OCNT_W-1:0] cnt;
  } bone_stats_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [IDX_W-1:0] in_joint_index = '0;
  logic in_is_tracked = 1'b0;
  logic signed [COORD_W-1:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [IDX_W-1:0] out_bone_index;
  logic [LEN_W-1:0] out_bone_length, out_length_min, out_length_max, out_length_mean;
  logic [SUM_W-1:0] out_length_sum;
  logic [SQ_W-1:0] out_length_sq_sum;
  logic [OCNT_W-1:0] out_sample_count;

  // Predictor state
  logic signed [COORD_W-1:0] jx[NJ], jy[NJ], jz[NJ];
  bit joint_seen[NJ];
  longint unsigned skel_count;
  longint unsigned bone_sum[NB], bone_sq[NB];
  int unsigned bone_min[NB], bone_max[NB];
  bone_stats_t expected_stats[$];

  int unsigned fail_count = 0;
  longint unsigned cycle_count = 0;
  bit idle_enable = 1'b0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  int unsigned hold_cnt = 0;
  logic holding;

  bone_length_statistics u_dut (.*);

  always #2 clk = ~clk;

  // Abort on runaway
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Count the receiver hold-off once it is requested
  always @(posedge clk) begin
    if (hold_req && !hold_done) begin
      if (hold_cnt == HOLD_CYCLES - 1) hold_done <= 1'b1;
      hold_cnt <= hold_cnt + 1;
    end
  end
  assign holding = hold_req && !hold_done;

  function automatic int unsigned parent_joint(int unsigned j);
    int unsigned tbl[NJ] = '{0, 0, 1, 2, 2, 4, 5, 6, 2, 8, 9, 10, 0, 12, 13, 14, 0, 16, 17, 18};
    return tbl[j];
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= root + b) begin
        v -= root + b;
        root = (root >> 1) + b;
      end else begin
        root >>= 1;
      end
      b >>= 2;
    end
    return root;
  endfunction

  function automatic longint unsigned add_sat(longint unsigned a, longint unsigned b,
                                              longint unsigned lim);
    return (b > lim - a) ? lim : a + b;
  endfunction

  // Advance the bone statistics for one accepted request
  function automatic void predict_joint(int unsigned j, bit trk,
                                        logic signed [15:0] x, y, z);
    int unsigned p, b;
    longint signed dx, dy, dz;
    longint unsigned d2, len, mean;
    bone_stats_t r;
    if (!trk || j >= NJ) return;
    jx[j] = x; jy[j] = y; jz[j] = z;
    joint_seen[j] = 1'b1;
    if (j == 0) begin
      if (skel_count < CNT_MAX) skel_count++;
      return;
    end
    p = parent_joint(j);
    b = j - 1;
    dx = longint'(x) - longint'(jx[p]);
    dy = longint'(y) - longint'(jy[p]);
    dz = longint'(z) - longint'(jz[p]);
    d2 = dx * dx + dy * dy + dz * dz;
    len = int_sqrt(d2);
    if (len > LEN_MAX) len = LEN_MAX;
    bone_sum[b] = add_sat(bone_sum[b], len, SUM_MAX);
    if (len > bone_max[b]) bone_max[b] = 32'(len);
    if (len < bone_min[b]) bone_min[b] = 32'(len);
    if (skel_count == 0) mean = 0;
    else begin
      mean = bone_sum[b] / skel_count;
      if (mean > LEN_MAX) mean = LEN_MAX;
    end
    bone_sq[b] = add_sat(bone_sq[b], len * len, SQ_MAX);
    r.bone = IDX_W'(b); r.len = LEN_W'(len); r.sum = SUM_W'(bone_sum[b]);
    r.lmin = LEN_W'(bone_min[b]); r.lmax = LEN_W'(bone_max[b]); r.mean = LEN_W'(mean);
    r.sq = SQ_W'(bone_sq[b]); r.cnt = OCNT_W'(skel_count);
    expected_stats.push_back(r);
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
    fail_count++;
  endtask

  // Send one request, honoring the sender idle pattern
  task automatic send_joint(int unsigned j, bit trk, logic signed [15:0] x, y, z);
    while (idle_enable && $urandom_range(99) < 10) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_joint_index <= IDX_W'(j);
    in_is_tracked <= trk;
    in_pos_x <= x; in_pos_y <= y; in_pos_z <= z;
    do @(posedge clk); while (!in_ready);
    predict_joint(j, trk, x, y, z);
  endtask

  function automatic logic signed [15:0] rnd_coord(int unsigned spread);
    if (spread == 0) return 16'($urandom);
    return 16'($urandom_range(2 * spread) - spread);
  endfunction

  // Full tracked skeleton with random content
  task automatic send_skeleton(int unsigned spread);
    for (int unsigned j = 0; j < NJ; j++)
      send_joint(j, 1'b1, rnd_coord(spread), rnd_coord(spread), rnd_coord(spread));
  endtask

  // Result side: drive ready, compare each result
  always @(posedge clk) begin
    bone_stats_t e;
    if (holding) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= !(idle_enable && $urandom_range(99) < 10);
    end
    if (rst_n && out_valid && out_ready) begin
      if (expected_stats.size() == 0) begin
        report_mismatch("unexpected result, bone_index", out_bone_index, 0);
      end else begin
        e = expected_stats.pop_front();
        if (out_bone_index !== e.bone) report_mismatch("bone_index", out_bone_index, e.bone);
        if (out_bone_length !== e.len) report_mismatch("bone_length", out_bone_length, e.len);
        if (out_length_sum !== e.sum) report_mismatch("length_sum", out_length_sum, e.sum);
        if (out_length_min !== e.lmin) report_mismatch("length_min", out_length_min, e.lmin);
        if (out_length_max !== e.lmax) report_mismatch("length_max", out_length_max, e.lmax);
        if (out_length_mean !== e.mean) report_mismatch("length_mean", out_length_mean, e.mean);
        if (out_length_sq_sum !== e.sq) report_mismatch("length_sq_sum", out_length_sq_sum, e.sq);
        if (out_sample_count !== e.cnt) report_mismatch("sample_count", out_sample_count, e.cnt);
      end
    end
  end

  // Extremes: max coordinates, zero length, ignored items
  task automatic test_directed();
    send_joint(5'd31, 1'b1, 16'sh7fff, 16'sh8000, 0);   // beyond joint range
    send_joint(0, 1'b0, 16'sh1234, 0, 0);               // untracked, no count
    send_joint(0, 1'b1, 16'sh8000, 16'sh8000, 16'sh8000);
    send_joint(1, 1'b1, 16'sh7fff, 16'sh7fff, 16'sh7fff); // longest length
    send_joint(2, 1'b1, 16'sh7fff, 16'sh7fff, 16'sh7fff); // zero length
    send_joint(3, 1'b0, 16'sh0000, 16'sh0000, 16'sh0000); // untracked
    send_joint(3, 1'b1, 16'sh7fff, 16'sh8000, 16'sh7fff);
    send_joint(4, 1'b1, 16'sh7000, 16'sh7fff, 16'sh7fff);
    send_joint(20, 1'b1, 16'sh0001, 16'sh0001, 16'sh0001);
    send_joint(0, 1'b1, 0, 0, 0);
    send_joint(1, 1'b1, 16'sh1000, 0, 0);                // one metre
    send_joint(0, 1'b1, 0, 0, 0);
    send_joint(1, 1'b1, 0, 16'sh0001, 0);                // minimum nonzero
    for (int unsigned j = 0; j < NJ; j++)
      send_joint(j, 1'b1, (j[0] ? 16'sh7fff : 16'sh8000), 16'sh7fff, (j[1] ? 16'sh8000 : 0));
  endtask

  // Random skeletons with noise and broken sequences
  task automatic test_random(int unsigned n_items);
    int unsigned sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(9))
        0: begin
          send_joint($urandom_range(31), 1'b0, 16'($urandom), 16'($urandom), 16'($urandom));
        end
        1: begin
          // truncated skeleton, then unchanged joints reused
          int unsigned stop = $urandom_range(NJ - 1, 1);
          send_joint(0, 1'b1, rnd_coord(8192), rnd_coord(8192), rnd_coord(8192));
          for (int unsigned j = 1; j < stop; j++) begin
            send_joint(j, 1'b1, rnd_coord(8192), rnd_coord(8192), rnd_coord(8192));
            sent++;
          end
          sent++;
        end
        2: begin
          int unsigned j = $urandom_range(NJ - 1, 1);
          if (joint_seen[parent_joint(j)])
            send_joint(j, 1'b1, 16'($urandom), 16'($urandom), 16'($urandom));
          sent++;
        end
        default: begin
          send_skeleton($urandom_range(3) == 0 ? 0 : 4096);
          sent += NJ;
        end
      endcase
    end
  endtask

  // Receiver holds off long while requests keep coming
  task automatic test_backpressure();
    hold_req = 1'b1;
    send_skeleton(2048);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_stats.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  initial begin
    skel_count = 0;
    for (int i = 0; i < NB; i++) begin
      bone_sum[i] = 0; bone_sq[i] = 0; bone_min[i] = LEN_MAX; bone_max[i] = 0;
    end
    for (int i = 0; i < NJ; i++) joint_seen[i] = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    idle_enable = 1'b1;
    test_random(250);
    idle_enable = 1'b0;
    test_random(100);
    idle_enable = 1'b1;
    test_random(150);
    wait_drained();
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ bone_length_statistics.f @@
hdl/bls_pkg.sv
hdl/bls_ctrl.sv
hdl/bls_datapath.sv
hdl/bone_length_statistics.sv
dv/bone_length_statistics_tb.sv
